### hw/rtl/dbq_pkg.sv
// package: request, response and internal command types, codes and limits for the deque
package dbq_pkg;

   localparam int DEFAULT_CAPACITY = 256;
   // largest capacity the command slot field can address
   localparam int CAPACITY_MAX     = 4096;
   localparam int SLOT_W           = $clog2(CAPACITY_MAX);
   localparam int COUNT_W          = 9;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [2:0] KIND_INS_HEAD = 3'd0;
   localparam logic [2:0] KIND_INS_TAIL = 3'd1;
   localparam logic [2:0] KIND_REM_HEAD = 3'd2;
   localparam logic [2:0] KIND_REM_TAIL = 3'd3;
   localparam logic [2:0] KIND_RD_HEAD  = 3'd4;
   localparam logic [2:0] KIND_RD_TAIL  = 3'd5;
   localparam logic [2:0] KIND_RD_INDEX = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] entry_x;
      logic [7:0] entry_y;
      logic [7:0] entry_symbol;
      logic [7:0] position;
   } req_type;

   typedef struct packed {
      logic [7:0]         out_x;
      logic [7:0]         out_y;
      logic [7:0]         out_symbol;
      logic [COUNT_W-1:0] count;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] symbol;
   } entry_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [SLOT_W-1:0]  slot;
      entry_type          entry;
      logic [COUNT_W-1:0] count;
      logic [1:0]         status;
   } cmd_type;

endpackage

### hw/rtl/dbq_front.sv
// front end: keeps head pointer and count, classifies requests into storage commands
module dbq_front import dbq_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_cmd
);

   localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CNT_W > 8) ? CNT_W : 8;
   localparam int SUM_W = PTR_W + 1;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             full, empty, accept;
   logic [PTR_W-1:0] head_dec, head_inc, slot;
   logic [IDX_W-1:0] idx, cnt_wide;
   logic [SUM_W-1:0] slot_sum;

   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   assign full     = (cnt_ff == CNT_W'(CAPACITY));
   assign empty    = (cnt_ff == '0);
   assign cnt_wide = IDX_W'(cnt_ff);
   assign head_dec = (head_ff == '0) ? PTR_W'(CAPACITY - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == PTR_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;

   always_comb begin
      unique case (req_data.kind)
         KIND_RD_HEAD:  idx = '0;
         KIND_RD_TAIL:  idx = cnt_wide - 1'b1;
         KIND_RD_INDEX: idx = IDX_W'(req_data.position);
         default:       idx = cnt_wide;
      endcase
   end

   // slot of an index from the head; index is below capacity whenever it is used
   assign slot_sum = {1'b0, head_ff} + {1'b0, idx[PTR_W-1:0]};
   assign slot     = (slot_sum >= SUM_W'(CAPACITY)) ? PTR_W'(slot_sum - SUM_W'(CAPACITY))
                                                    : slot_sum[PTR_W-1:0];

   always_comb begin
      head_in             = head_ff;
      cnt_in              = cnt_ff;
      push_cmd.op         = OP_NONE;
      push_cmd.slot       = SLOT_W'(slot);
      push_cmd.entry.x    = req_data.entry_x;
      push_cmd.entry.y    = req_data.entry_y;
      push_cmd.entry.symbol = req_data.entry_symbol;
      push_cmd.status     = ST_OK;
      unique case (req_data.kind)
         KIND_INS_HEAD, KIND_INS_TAIL: begin
            if (full) begin
               push_cmd.status = ST_FULL;
            end else begin
               push_cmd.op = OP_WRITE;
               cnt_in      = cnt_ff + 1'b1;
               if (req_data.kind == KIND_INS_HEAD) begin
                  head_in       = head_dec;
                  push_cmd.slot = SLOT_W'(head_dec);
               end
            end
         end
         KIND_REM_HEAD, KIND_REM_TAIL: begin
            if (empty) begin
               push_cmd.status = ST_EMPTY;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               if (req_data.kind == KIND_REM_HEAD) begin
                  head_in = head_inc;
               end
            end
         end
         KIND_RD_HEAD, KIND_RD_TAIL, KIND_RD_INDEX: begin
            if (empty) begin
               push_cmd.status = ST_EMPTY;
            end else if (idx >= cnt_wide) begin
               push_cmd.status = ST_RANGE;
            end else begin
               push_cmd.op = OP_READ;
            end
         end
         default: begin
            // undefined kind: no change, plain ok response
         end
      endcase
      push_cmd.count = COUNT_W'(cnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         cnt_ff  <= '0;
      end else if (accept) begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

### hw/rtl/dbq_queue.sv
// small command queue between the front end and the storage back end
module dbq_queue import dbq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QF_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slots_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QF_W-1:0]  fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != QF_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/dbq_back.sv
// back end: entry storage, at most one access per command, registered response
module dbq_back import dbq_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    pop_valid,
   output logic    pop_ready,
   input  cmd_type pop_cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   entry_type          mem [CAPACITY];
   entry_type          rd_ff;
   logic               out_valid_ff;
   logic               have_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [1:0]         status_ff;
   logic               fire;
   logic [PTR_W-1:0]   addr;

   assign pop_ready = !out_valid_ff || rsp_ready;
   assign fire      = pop_valid && pop_ready;
   assign addr      = pop_cmd.slot[PTR_W-1:0];
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         have_ff   <= (pop_cmd.op == OP_READ);
         count_ff  <= pop_cmd.count;
         status_ff <= pop_cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && pop_cmd.op == OP_WRITE) begin
         mem[addr] <= pop_cmd.entry;
      end
      if (fire && pop_cmd.op == OP_READ) begin
         rd_ff <= mem[addr];
      end
   end

   // anything but a good read reports zero entry fields
   assign rsp_data.out_x      = have_ff ? rd_ff.x : 8'd0;
   assign rsp_data.out_y      = have_ff ? rd_ff.y : 8'd0;
   assign rsp_data.out_symbol = have_ff ? rd_ff.symbol : 8'd0;
   assign rsp_data.count      = count_ff;
   assign rsp_data.status     = status_ff;

endmodule

### hw/rtl/bounded_deque_with_indexed_read.sv
// top level: fixed-capacity deque with head, tail and indexed reads
//
//  channel  handshake            payload    direction
//  req      req_valid/req_ready  req_type   in:  one operation
//  rsp      rsp_valid/rsp_ready  rsp_type   out: one response per request
//
// one request per cycle sustained while the rsp side keeps taking responses;
// a taken request waits in a queue slot, then makes at most one storage access,
// and its response, with the read data, is held in registered output fields.
// head pointer and count live in the front end and update at acceptance.
// reset clears pointer, count and queue; entry storage is not cleared.
// the two-entry command queue lets a stalled rsp side hold the back end
// while the front end keeps taking requests until the queue fills.
module bounded_deque_with_indexed_read import dbq_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    push_valid, push_ready, pop_valid, pop_ready;
   cmd_type push_cmd, pop_cmd;

   dbq_front #(
      .CAPACITY (CAPACITY)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   dbq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   dbq_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### verif/bounded_deque_with_indexed_read_tb.sv
// testbench for the bounded deque: shadow deque predicts every response, random idling both sides
module bounded_deque_with_indexed_read_tb;
   import dbq_pkg::*;

   localparam int DEPTH = DEFAULT_CAPACITY;
   localparam int STALL_LIMIT = 2000;
   // kind code with no operation behind it
   localparam logic [2:0] KIND_UNUSED = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bounded_deque_with_indexed_read #(
      .CAPACITY(DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow deque
   entry_type shadow_slot [DEPTH];
   int        head_slot = 0;
   int        held = 0;

   rsp_type pending_rsp [$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int sent_count = 0;
   int rsp_count = 0;
   int idle_cycles = 0;
   int full_hits = 0;
   int empty_hits = 0;
   int range_hits = 0;
   int peak_held = 0;

   function automatic rsp_type next_response(input req_type r);
      rsp_type   o;
      entry_type e;
      int        idx;
      o = '0;
      o.status = ST_OK;
      e.x = r.entry_x;
      e.y = r.entry_y;
      e.symbol = r.entry_symbol;
      case (r.kind)
         KIND_INS_HEAD, KIND_INS_TAIL: begin
            if (held >= DEPTH) begin
               o.status = ST_FULL;
            end else if (r.kind == KIND_INS_HEAD) begin
               head_slot = (head_slot + DEPTH - 1) % DEPTH;
               shadow_slot[head_slot] = e;
               held++;
            end else begin
               shadow_slot[(head_slot + held) % DEPTH] = e;
               held++;
            end
         end
         KIND_REM_HEAD, KIND_REM_TAIL: begin
            if (held == 0) begin
               o.status = ST_EMPTY;
            end else begin
               if (r.kind == KIND_REM_HEAD) head_slot = (head_slot + 1) % DEPTH;
               held--;
            end
         end
         KIND_RD_HEAD, KIND_RD_TAIL, KIND_RD_INDEX: begin
            if (held == 0) begin
               o.status = ST_EMPTY;
            end else begin
               idx = (r.kind == KIND_RD_HEAD) ? 0 :
                     (r.kind == KIND_RD_TAIL) ? held - 1 : int'(r.position);
               if (idx >= held) begin
                  o.status = ST_RANGE;
               end else begin
                  e = shadow_slot[(head_slot + idx) % DEPTH];
                  o.out_x = e.x;
                  o.out_y = e.y;
                  o.out_symbol = e.symbol;
               end
            end
         end
         default: ;
      endcase
      o.count = COUNT_W'(held);
      if (o.status == ST_FULL) full_hits++;
      if (o.status == ST_EMPTY) empty_hits++;
      if (o.status == ST_RANGE) range_hits++;
      if (held > peak_held) peak_held = held;
      return o;
   endfunction

   function automatic req_type make_req(input logic [2:0] kind, input logic [7:0] x,
                                        input logic [7:0] y, input logic [7:0] sym,
                                        input logic [7:0] pos);
      req_type r;
      r.kind = kind;
      r.entry_x = x;
      r.entry_y = y;
      r.entry_symbol = sym;
      r.position = pos;
      return r;
   endfunction

   // weights in percent; what is left over goes to reads
   function automatic req_type random_request(input int ins_w, input int rem_w,
                                              input int odd_w);
      req_type r;
      int      roll;
      r = make_req(KIND_RD_HEAD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      roll = $urandom_range(99);
      if (roll < ins_w) begin
         r.kind = $urandom_range(1) ? KIND_INS_TAIL : KIND_INS_HEAD;
      end else if (roll < ins_w + rem_w) begin
         r.kind = $urandom_range(1) ? KIND_REM_TAIL : KIND_REM_HEAD;
      end else if (roll < ins_w + rem_w + odd_w) begin
         r.kind = KIND_UNUSED;
      end else begin
         case ($urandom_range(2))
            0: r.kind = KIND_RD_HEAD;
            1: r.kind = KIND_RD_TAIL;
            default: r.kind = KIND_RD_INDEX;
         endcase
      end
      // steer half the index reads inside the list, some right at its end
      if (r.kind == KIND_RD_INDEX && held > 0) begin
         roll = $urandom_range(7);
         if (roll < 4) r.position = 8'($urandom_range(held - 1));
         else if (roll == 4 && held < DEPTH) r.position = 8'(held);
      end
      return r;
   endfunction

   task automatic send_request(input req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      pending_rsp.push_back(next_response(r));
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_corner_requests();
      send_request(make_req(KIND_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_req(KIND_RD_TAIL, 8'hff, 8'hff, 8'hff, 8'hff));
      send_request(make_req(KIND_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_req(KIND_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_req(KIND_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_req(KIND_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff));
      send_request(make_req(KIND_INS_TAIL, 8'h00, 8'h00, 8'h00, 8'hff));
      // head insert on a one-entry list with the head at slot zero wraps the head pointer
      send_request(make_req(KIND_INS_HEAD, 8'hff, 8'hff, 8'hff, 8'h00));
      send_request(make_req(KIND_INS_TAIL, 8'ha5, 8'h5a, 8'h3c, 8'h00));
      send_request(make_req(KIND_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_req(KIND_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_req(KIND_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h01));
      send_request(make_req(KIND_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h03));
      send_request(make_req(KIND_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'hff));
      send_request(make_req(KIND_UNUSED, 8'h12, 8'h34, 8'h56, 8'h02));
      send_request(make_req(KIND_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_req(KIND_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_req(KIND_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_req(KIND_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_req(KIND_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_req(KIND_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   task automatic test_fill_to_full();
      while (held < DEPTH) send_request(random_request(80, 0, 0));
      // inserts against a full list, mixed with reads and unused kinds
      repeat (20) send_request(random_request(50, 0, 5));
   endtask

   task automatic test_drain_to_empty();
      while (held > 0) send_request(random_request(0, 80, 0));
      repeat (20) send_request(random_request(0, 50, 5));
   endtask

   task automatic test_random_mix(input int n, input int ins_w, input int rem_w);
      repeat (n) send_request(random_request(ins_w, rem_w, 3));
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // receiver side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // both handshakes are stable at the falling edge and complete at the next rising one
   always @(negedge clock) begin : rsp_check
      rsp_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (pending_rsp.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("out_x", 16'(want.out_x), 16'(rsp_data.out_x));
               check_field("out_y", 16'(want.out_y), 16'(rsp_data.out_y));
               check_field("out_symbol", 16'(want.out_symbol), 16'(rsp_data.out_symbol));
               check_field("count", 16'(want.count), 16'(rsp_data.count));
               check_field("status", 16'(want.status), 16'(rsp_data.status));
            end
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("bounded_deque_with_indexed_read_tb failed");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_corner_requests();
      wait_drained();

      send_idle_pct = 68;
      test_fill_to_full();
      wait_drained();

      send_idle_pct = 0;
      recv_stall_pct = 68;
      test_drain_to_empty();
      wait_drained();

      send_idle_pct = 22;
      recv_stall_pct = 22;
      test_random_mix(170, 45, 35);
      wait_drained();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_mix(150, 35, 45);
      wait_drained();
      repeat (4) @(posedge clock);

      $display("run: %0d requests, %0d responses, peak occupancy %0d of %0d",
               sent_count, rsp_count, peak_held, DEPTH);
      $display("flags seen: %0d full inserts, %0d empty accesses, %0d out-of-range reads",
               full_hits, empty_hits, range_hits);
      if (error_count == 0) begin
         $display("bounded_deque_with_indexed_read_tb passed");
      end else begin
         $display("bounded_deque_with_indexed_read_tb failed");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/dbq_pkg.sv
hw/rtl/dbq_front.sv
hw/rtl/dbq_queue.sv
hw/rtl/dbq_back.sv
hw/rtl/bounded_deque_with_indexed_read.sv
verif/bounded_deque_with_indexed_read_tb.sv
